[sv/pst_pkg.sv]
`timescale 1ns / 1ps

package pst_pkg;

  localparam int DEFAULT_ENTRIES = 32;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic [63:0] NO_MIN = '1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  probe_index;
    logic [63:0] cycles;
  } pst_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_index;
    logic [31:0] sample_count;
    logic [63:0] cycle_sum;
    logic [63:0] cycle_min;
    logic [63:0] cycle_max;
  } pst_rsp_t;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
  } pst_entry_t;

  localparam pst_entry_t ENTRY_INIT = '{count: 32'd0, sum: 64'd0, min: NO_MIN, max: 64'd0};

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic finish;
  } pst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_walk;
    logic walk_last;
    logic slot_free;
  } pst_sts_t;

endpackage

[sv/pst_ctrl.sv]
`timescale 1ns / 1ps

module pst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pst_pkg::pst_sts_t sts,
  output pst_pkg::pst_cmd_t cmd
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CLEAR  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
        if (req_valid) begin
          state_next = sts.start_walk ? S_CLEAR : S_FINISH;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.walk_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register can take the response
        cmd.finish = sts.slot_free;
        if (sts.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/pst_dp.sv]
`timescale 1ns / 1ps

module pst_dp #(
  parameter int ENTRIES = pst_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  pst_pkg::pst_req_t req,
  input  pst_pkg::pst_cmd_t cmd,
  output pst_pkg::pst_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pst_pkg::pst_rsp_t rsp
);
  import pst_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int XW = (UW > 5) ? UW : 5;
  localparam int YW = (AW > 5) ? AW : 5;

  pst_entry_t mem [ENTRIES];

  pst_req_t   req_q;
  pst_entry_t rd_q;
  logic [UW-1:0] used;
  logic [UW-1:0] used_next;
  logic [UW-1:0] walk;
  logic          rsp_valid_next;
  pst_rsp_t      rsp_next;

  logic [XW-1:0] used_x;
  logic [XW-1:0] idx_x;
  logic [YW-1:0] idx_y;
  logic [YW-1:0] in_idx_y;
  logic          hit;
  logic          full;
  pst_entry_t    upd;
  logic          we;
  logic [AW-1:0] wr_addr;
  pst_entry_t    wr_data;

  assign used_x   = XW'(used);
  assign idx_x    = XW'(req_q.probe_index);
  assign idx_y    = YW'(req_q.probe_index);
  assign in_idx_y = YW'(req.probe_index);
  assign hit      = idx_x < used_x;
  assign full     = used == UW'(ENTRIES);

  // fold one sample into the entry read at accept
  always_comb begin
    upd.count = rd_q.count + 32'd1;
    upd.sum   = rd_q.sum + req_q.cycles;
    upd.min   = (req_q.cycles < rd_q.min) ? req_q.cycles : rd_q.min;
    upd.max   = (req_q.cycles > rd_q.max) ? req_q.cycles : rd_q.max;
  end

  always_comb begin
    rsp_next = '0;
    unique case (req_q.operation)
      OP_ALLOC: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status       = ST_OK;
          rsp_next.entry_index  = used_x[4:0];
          rsp_next.sample_count = ENTRY_INIT.count;
          rsp_next.cycle_sum    = ENTRY_INIT.sum;
          rsp_next.cycle_min    = ENTRY_INIT.min;
          rsp_next.cycle_max    = ENTRY_INIT.max;
        end
      end
      OP_RECORD: begin
        rsp_next.entry_index = req_q.probe_index;
        if (!hit) begin
          rsp_next.status = ST_BAD_INDEX;
        end else begin
          rsp_next.status       = ST_OK;
          rsp_next.sample_count = upd.count;
          rsp_next.cycle_sum    = upd.sum;
          rsp_next.cycle_min    = upd.min;
          rsp_next.cycle_max    = upd.max;
        end
      end
      OP_CLEAR: begin
        rsp_next.status = ST_OK;
      end
      OP_READ: begin
        rsp_next.entry_index = req_q.probe_index;
        if (!hit) begin
          rsp_next.status = ST_BAD_INDEX;
        end else begin
          rsp_next.status       = ST_OK;
          rsp_next.sample_count = rd_q.count;
          rsp_next.cycle_sum    = rd_q.sum;
          rsp_next.cycle_min    = rd_q.min;
          rsp_next.cycle_max    = rd_q.max;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // single write port: clear walk, allocate initialisation or record update
  always_comb begin
    we = cmd.clear_step
         || (cmd.finish && req_q.operation == OP_ALLOC && !full)
         || (cmd.finish && req_q.operation == OP_RECORD && hit);
    if (cmd.clear_step) begin
      wr_addr = walk[AW-1:0];
      wr_data = ENTRY_INIT;
    end else if (req_q.operation == OP_ALLOC) begin
      wr_addr = used[AW-1:0];
      wr_data = ENTRY_INIT;
    end else begin
      wr_addr = idx_y[AW-1:0];
      wr_data = upd;
    end
  end

  assign used_next = (cmd.finish && req_q.operation == OP_ALLOC && !full)
                     ? used + UW'(1) : used;
  assign rsp_valid_next = cmd.finish ? 1'b1 : (rsp_valid && rsp_stall);

  assign sts.start_walk = (req.operation == OP_CLEAR) && (used != '0);
  assign sts.walk_last  = walk == (used - UW'(1));
  assign sts.slot_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      used      <= used_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
      walk  <= '0;
    end else if (cmd.clear_step) begin
      walk <= walk + UW'(1);
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q <= mem[in_idx_y[AW-1:0]];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[sv/probe_statistics_table_unit.sv]
`timescale 1ns / 1ps

// Probe statistics table: one response per request. Allocate, record and read
// read the entry memory at the accepting edge; once the result register is free,
// allocate and record update the memory and all three load the response register.
// A new request is not accepted until the previous one is finished. Clear-all walks
// every allocated entry first, rewriting one memory entry per cycle through the
// single write port. A new request is taken while an earlier response still waits
// on rsp_stall; the block then holds the next response until the result register
// frees. No clearing pass follows reset.
module probe_statistics_table_unit #(
  parameter int ENTRIES = pst_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pst_pkg::pst_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pst_pkg::pst_rsp_t rsp
);
  import pst_pkg::*;

  pst_cmd_t cmd;
  pst_sts_t sts;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pst_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous one still in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                   || rsp.status == ST_BAD_INDEX))
    else $error("undefined response status");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |->
      (rsp.entry_index == '0 && rsp.sample_count == '0 && rsp.cycle_sum == '0))
    else $error("table-full response carries statistics");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_OK && rsp.sample_count != '0) |->
      (rsp.cycle_min <= rsp.cycle_max))
    else $error("entry minimum exceeds maximum");

endmodule

[tb/probe_statistics_table_unit_test.sv]
`timescale 1ns / 1ps

module probe_statistics_table_unit_test;
  import pst_pkg::*;

  localparam int ENTRIES     = DEFAULT_ENTRIES;
  localparam int RANDOM_REQS = 530;
  localparam int CALM_TAIL   = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 150;
  localparam int DRAIN_WAIT  = ENTRIES + 20;
  localparam int CYCLE_LIMIT = 300000;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  pst_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  pst_rsp_t rsp;

  probe_statistics_table_unit #(.ENTRIES(ENTRIES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table
  int          alloc_count;
  logic [31:0] stat_count [ENTRIES];
  logic [63:0] stat_sum   [ENTRIES];
  logic [63:0] stat_min   [ENTRIES];
  logic [63:0] stat_max   [ENTRIES];

  pst_req_t pending_reqs [$];
  pst_rsp_t expected_rsps [$];
  pst_rsp_t want_rsp;

  int total_reqs;
  int reqs_taken;
  int rsps_checked;
  int errors;
  int full_seen;
  int bad_index_seen;
  int src_gap;
  int sink_gap;
  int hold_left;
  bit hold_done;
  int cycle_count;

  function automatic pst_rsp_t predict_rsp(pst_req_t r);
    pst_rsp_t res;
    int       e;
    res = '0;
    res.status = ST_OK;
    case (r.operation)
      OP_ALLOC: begin
        if (alloc_count >= ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          e = alloc_count;
          alloc_count++;
          stat_count[e] = '0;
          stat_sum[e]   = '0;
          stat_min[e]   = NO_MIN;
          stat_max[e]   = '0;
          res.entry_index  = e[4:0];
          res.sample_count = stat_count[e];
          res.cycle_sum    = stat_sum[e];
          res.cycle_min    = stat_min[e];
          res.cycle_max    = stat_max[e];
        end
      end
      OP_CLEAR: begin
        for (e = 0; e < alloc_count; e++) begin
          stat_count[e] = '0;
          stat_sum[e]   = '0;
          stat_min[e]   = NO_MIN;
          stat_max[e]   = '0;
        end
      end
      default: begin
        e = int'(r.probe_index);
        res.entry_index = r.probe_index;
        if (e >= alloc_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          if (r.operation == OP_RECORD) begin
            stat_sum[e]   = stat_sum[e] + r.cycles;
            stat_count[e] = stat_count[e] + 32'd1;
            if (r.cycles < stat_min[e]) stat_min[e] = r.cycles;
            if (r.cycles > stat_max[e]) stat_max[e] = r.cycles;
          end
          res.sample_count = stat_count[e];
          res.cycle_sum    = stat_sum[e];
          res.cycle_min    = stat_min[e];
          res.cycle_max    = stat_max[e];
        end
      end
    endcase
    return res;
  endfunction

  function automatic pst_req_t make_req(logic [1:0] op, logic [4:0] idx, logic [63:0] cyc);
    pst_req_t r;
    r.operation   = op;
    r.probe_index = idx;
    r.cycles      = cyc;
    return r;
  endfunction

  function automatic logic [63:0] rand_cycles();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = 64'($urandom_range(0, 1000));
      1:       v = {$urandom, $urandom};
      2:       v = NO_MIN - 64'($urandom_range(0, 1000));
      3:       v = $urandom_range(0, 1) ? NO_MIN : 64'd0;
      4:       v = 64'd1 << $urandom_range(0, 63);
      default: v = {32'd0, $urandom};
    endcase
    return v;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_rsp(req));
        reqs_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && reqs_taken < total_reqs - CALM_TAIL &&
                     $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 18);
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and stall control
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp);
          errors++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          rsps_checked++;
          if (want_rsp.status == ST_FULL) full_seen++;
          if (want_rsp.status == ST_BAD_INDEX) bad_index_seen++;
          if (rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
            errors++;
          end
          if (rsp.entry_index !== want_rsp.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want_rsp.entry_index,
                   rsp.entry_index);
            errors++;
          end
          if (rsp.sample_count !== want_rsp.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want_rsp.sample_count,
                   rsp.sample_count);
            errors++;
          end
          if (rsp.cycle_sum !== want_rsp.cycle_sum) begin
            $error("cycle_sum: expected %h, got %h", want_rsp.cycle_sum, rsp.cycle_sum);
            errors++;
          end
          if (rsp.cycle_min !== want_rsp.cycle_min) begin
            $error("cycle_min: expected %h, got %h", want_rsp.cycle_min, rsp.cycle_min);
            errors++;
          end
          if (rsp.cycle_max !== want_rsp.cycle_max) begin
            $error("cycle_max: expected %h, got %h", want_rsp.cycle_max, rsp.cycle_max);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the table backs up into its input
      if (!hold_done && rsps_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rsp_stall <= 1'b1;
      end else if (reqs_taken < total_reqs - CALM_TAIL && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 18);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timed out after %0d cycles, %0d responses outstanding", cycle_count,
             expected_rsps.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int          n;
    int          pick;
    int          gen_used;
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [63:0] cyc;

    // unallocated index and clear on an empty table
    pending_reqs.push_back(make_req(OP_READ, 5'd0, 64'd0));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd31, NO_MIN));
    pending_reqs.push_back(make_req(OP_CLEAR, 5'd0, 64'd0));
    // fresh entry statistics, min/max extremes and sum wrap
    pending_reqs.push_back(make_req(OP_ALLOC, 5'd31, NO_MIN));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, 64'd0));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd0, NO_MIN));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd0, 64'd1));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd0, 64'd0));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, NO_MIN));
    pending_reqs.push_back(make_req(OP_ALLOC, 5'd0, 64'd0));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd1, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd2, 64'd7));
    pending_reqs.push_back(make_req(OP_READ, 5'd31, 64'd0));
    pending_reqs.push_back(make_req(OP_READ, 5'd1, 64'd0));
    // clear keeps entries allocated but empties them
    pending_reqs.push_back(make_req(OP_CLEAR, 5'd31, NO_MIN));
    pending_reqs.push_back(make_req(OP_READ, 5'd0, 64'd0));
    pending_reqs.push_back(make_req(OP_RECORD, 5'd1, 64'h0000_0000_ffff_ffff));
    pending_reqs.push_back(make_req(OP_READ, 5'd1, 64'd0));
    gen_used = 2;

    // mostly valid record/read traffic, with allocations that fill the table and go on past it
    for (n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (gen_used > 0 && $urandom_range(0, 9) != 0) idx = 5'($urandom_range(0, gen_used - 1));
      else idx = 5'($urandom_range(0, 31));
      cyc = rand_cycles();
      if (pick < 18) begin
        op = OP_ALLOC;
        if (gen_used < ENTRIES) gen_used++;
      end else if (pick < 21) begin
        op = OP_CLEAR;
      end else if (pick < 72) begin
        op = OP_RECORD;
      end else begin
        op = OP_READ;
      end
      pending_reqs.push_back(make_req(op, idx, cyc));
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (reqs_taken < total_reqs || expected_rsps.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests, checked %0d responses in %0d cycles.", reqs_taken,
             rsps_checked, cycle_count);
    $display("Responses with table full: %0d, with unallocated index: %0d.", full_seen,
             bad_index_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/pst_pkg.sv
sv/pst_ctrl.sv
sv/pst_dp.sv
sv/probe_statistics_table_unit.sv
tb/probe_statistics_table_unit_test.sv
